// File: rtl/tce_pkg.sv
// Shared types and constants of the text console engine.
package tce_pkg;

    // Command codes on the input cmd field
    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_READ_CELL  = 2'd3
    } t_cmd;

    // Operations after classification by the front end
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_IGNORE,
        OP_SET_CURSOR,
        OP_CLEAR,
        OP_READ
    } t_op;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_FILL
    } t_state;

    localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [7:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE  = 8'h7E;
    localparam logic [7:0] BLANK_CHAR      = 8'h20;
    localparam logic [7:0] RESET_ATTR      = 8'h0F;

    // Field widths fixed by the port list and the largest screen
    localparam int CELL_W  = 16;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    localparam int LIN_W   = 13;

    localparam int QUEUE_DEPTH = 2;

    // One classified command as it waits in the queue
    typedef struct packed {
        t_op               op;
        logic [CELL_W-1:0] glyph;
        logic [LIN_W-1:0]  lin;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [IDX_W-1:0]  idx;
        logic              idx_ok;
    } t_entry;

endpackage

// File: rtl/tce_front.sv
// Front end: decodes a command beat, clamps the cursor request and checks the read index.
module tce_front #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_char_code,
    input  logic [7:0]          i_color,
    input  logic signed [7:0]   i_col_x,
    input  logic signed [7:0]   i_row_y,
    input  logic [10:0]         i_cell_index,
    output tce_pkg::t_entry     o_entry
);

    localparam int CELLS = ROWS * COLUMNS;

    logic [tce_pkg::COL_W-1:0] x_cl;
    logic [tce_pkg::ROW_W-1:0] y_cl;

    // Clamp the requested column and row to the screen
    always_comb begin
        priority if (i_col_x[7]) begin
            x_cl = '0;
        end else if ({1'b0, i_col_x} >= 9'(COLUMNS)) begin
            x_cl = tce_pkg::COL_W'(COLUMNS - 1);
        end else begin
            x_cl = tce_pkg::COL_W'(i_col_x);
        end
        priority if (i_row_y[7]) begin
            y_cl = '0;
        end else if ({1'b0, i_row_y} >= 9'(ROWS)) begin
            y_cl = tce_pkg::ROW_W'(ROWS - 1);
        end else begin
            y_cl = tce_pkg::ROW_W'(i_row_y);
        end
    end

    // Classify the command
    always_comb begin
        o_entry.glyph  = {i_color, i_char_code};
        o_entry.col    = x_cl;
        o_entry.row    = y_cl;
        o_entry.lin    = tce_pkg::LIN_W'(tce_pkg::LIN_W'(y_cl) * tce_pkg::LIN_W'(COLUMNS)
                         + tce_pkg::LIN_W'(x_cl));
        o_entry.idx    = i_cell_index;
        o_entry.idx_ok = (32'(i_cell_index) < 32'(CELLS));
        unique case (tce_pkg::t_cmd'(i_cmd))
            tce_pkg::CMD_PUT_CHAR: begin
                priority if (i_char_code == tce_pkg::NEWLINE_CODE) begin
                    o_entry.op = tce_pkg::OP_NEWLINE;
                end else if (i_char_code >= tce_pkg::FIRST_PRINTABLE &&
                             i_char_code <= tce_pkg::LAST_PRINTABLE) begin
                    o_entry.op = tce_pkg::OP_PUT;
                end else begin
                    o_entry.op = tce_pkg::OP_IGNORE;
                end
            end
            tce_pkg::CMD_SET_CURSOR: o_entry.op = tce_pkg::OP_SET_CURSOR;
            tce_pkg::CMD_CLEAR:      o_entry.op = tce_pkg::OP_CLEAR;
            tce_pkg::CMD_READ_CELL:  o_entry.op = tce_pkg::OP_READ;
            default:                 o_entry.op = tce_pkg::OP_IGNORE;
        endcase
    end

endmodule

// File: rtl/tce_queue.sv
// Short queue of classified commands between the front and back ends.
module tce_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tce_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tce_pkg::t_entry o_entry
);

    localparam int PTR_W = (tce_pkg::QUEUE_DEPTH > 1) ? $clog2(tce_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tce_pkg::QUEUE_DEPTH + 1);

    tce_pkg::t_entry r_slot [tce_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(tce_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold the beat in its slot
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

// File: rtl/tce_back.sv
// Back end: cell memory, cursor and the sequencer for put, read, clear and scroll.
module tce_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_wdata,
    input  logic                        i_q_valid,
    input  tce_pkg::t_entry             i_q_entry,
    output logic                        o_q_pop,
    output logic                        o_init_busy,
    output logic                        o_valid,
    output logic [tce_pkg::POS_W-1:0]   o_cursor_pos,
    output logic [tce_pkg::CELL_W-1:0]  o_cell_value,
    output logic                        o_scrolled
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int FILL_START = (ROWS - 1) * COLUMNS;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

    logic [tce_pkg::CELL_W-1:0] r_mem [CELLS];
    logic [tce_pkg::CELL_W-1:0] r_rd_data;

    tce_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_lin, n_lin;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_wr_pend, n_wr_pend;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_rd_ok, n_rd_ok;
    logic [7:0]    r_clear_attr;

    logic                       r_out_valid, n_out_valid;
    logic [tce_pkg::POS_W-1:0]  r_out_cursor, n_out_cursor;
    logic [tce_pkg::CELL_W-1:0] r_out_value, n_out_value;
    logic                       r_out_scrolled, n_out_scrolled;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [tce_pkg::CELL_W-1:0] mem_wdata;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       emit;

    assign o_init_busy  = (r_state == tce_pkg::ST_INIT);
    assign o_valid      = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_cell_value = r_out_value;
    assign o_scrolled   = r_out_scrolled;

    // Sequencer: next state, memory controls and result
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_lin          = r_lin;
        n_col          = r_col;
        n_row          = r_row;
        n_wr_pend      = 1'b0;
        n_wr_addr      = r_wr_addr;
        n_rd_ok        = r_rd_ok;
        n_out_value    = '0;
        n_out_scrolled = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = r_cnt;
        mem_wdata      = {r_clear_attr, tce_pkg::BLANK_CHAR};
        rd_en          = 1'b0;
        rd_addr        = r_cnt;
        o_q_pop        = 1'b0;
        emit           = 1'b0;

        unique case (r_state)
            // Blank the store after reset in the reset attribute
            tce_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {tce_pkg::RESET_ATTR, tce_pkg::BLANK_CHAR};
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    n_state = tce_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tce_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_entry.op)
                        tce_pkg::OP_PUT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_lin;
                            mem_wdata = i_q_entry.glyph;
                            if (r_col != LAST_COL) begin
                                n_col = r_col + 1'b1;
                                n_lin = r_lin + 1'b1;
                                emit  = 1'b1;
                            end else if (r_row != LAST_ROW) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                                n_lin = r_lin + 1'b1;
                                emit  = 1'b1;
                            end else begin
                                n_col   = '0;
                                n_row   = LAST_ROW;
                                n_lin   = AW'(FILL_START);
                                n_cnt   = AW'(COLUMNS);
                                n_state = tce_pkg::ST_SCROLL;
                            end
                        end
                        tce_pkg::OP_NEWLINE: begin
                            if (r_row != LAST_ROW) begin
                                n_col = '0;
                                n_row = r_row + 1'b1;
                                n_lin = r_lin + AW'(COLUMNS) - AW'(r_col);
                                emit  = 1'b1;
                            end else begin
                                n_col   = '0;
                                n_row   = LAST_ROW;
                                n_lin   = AW'(FILL_START);
                                n_cnt   = AW'(COLUMNS);
                                n_state = tce_pkg::ST_SCROLL;
                            end
                        end
                        tce_pkg::OP_IGNORE: begin
                            emit = 1'b1;
                        end
                        tce_pkg::OP_SET_CURSOR: begin
                            n_col = CW'(i_q_entry.col);
                            n_row = RW'(i_q_entry.row);
                            n_lin = AW'(i_q_entry.lin);
                            emit  = 1'b1;
                        end
                        tce_pkg::OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_lin   = '0;
                            n_cnt   = '0;
                            n_state = tce_pkg::ST_CLEAR;
                        end
                        tce_pkg::OP_READ: begin
                            rd_en   = i_q_entry.idx_ok;
                            rd_addr = AW'(i_q_entry.idx);
                            n_rd_ok = i_q_entry.idx_ok;
                            n_state = tce_pkg::ST_READ;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            // Return the registered cell
            tce_pkg::ST_READ: begin
                emit        = 1'b1;
                n_out_value = r_rd_ok ? r_rd_data : '0;
                n_state     = tce_pkg::ST_IDLE;
            end
            // Blank the store in the clear attribute
            tce_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = '0;
                    emit    = 1'b1;
                    n_state = tce_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // Copy each cell one row up: read the source, write it in the next cycle
            tce_pkg::ST_SCROLL: begin
                rd_en     = 1'b1;
                n_wr_pend = 1'b1;
                n_wr_addr = r_cnt - AW'(COLUMNS);
                mem_we    = r_wr_pend;
                mem_waddr = r_wr_addr;
                mem_wdata = r_rd_data;
                if (r_cnt == LAST_CELL) begin
                    n_cnt   = AW'(FILL_START);
                    n_state = tce_pkg::ST_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // Drain the last copy, then blank the bottom row
            tce_pkg::ST_FILL: begin
                mem_we = 1'b1;
                if (r_wr_pend) begin
                    mem_waddr = r_wr_addr;
                    mem_wdata = r_rd_data;
                end else if (r_cnt == LAST_CELL) begin
                    n_cnt          = '0;
                    emit           = 1'b1;
                    n_out_scrolled = 1'b1;
                    n_state        = tce_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = tce_pkg::ST_IDLE;
            end
        endcase

        n_out_valid  = emit;
        n_out_cursor = emit ? tce_pkg::POS_W'(n_lin) : r_out_cursor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tce_pkg::ST_INIT;
            r_cnt        <= '0;
            r_lin        <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_wr_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clear_attr <= tce_pkg::RESET_ATTR;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_lin       <= n_lin;
            r_col       <= n_col;
            r_row       <= n_row;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_clear_attr <= i_cfg_wdata;
            end
        end
    end

    // Hold result payload and scroll bookkeeping
    always_ff @(posedge i_clk) begin
        r_wr_addr      <= n_wr_addr;
        r_rd_ok        <= n_rd_ok;
        r_out_cursor   <= n_out_cursor;
        r_out_value    <= n_out_value;
        r_out_scrolled <= n_out_scrolled;
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Linear cursor tracks row and column
    a_lin_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_lin) == 32'(r_row) * COLUMNS + 32'(r_col))
        else $error("linear cursor out of step with row and column");

    // Cursor stays on the screen
    a_lin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lin <= LAST_CELL)
        else $error("cursor beyond last cell");

    // No result while the reset pass runs
    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tce_pkg::ST_INIT) |=> !r_out_valid)
        else $error("result during reset pass");

    // A scrolled result comes only out of the fill phase
    a_scroll_from_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scrolled) |-> $past(r_state) == tce_pkg::ST_FILL)
        else $error("scrolled flag without a fill");

    // Queue is not drained during scroll or fill
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tce_pkg::ST_SCROLL || r_state == tce_pkg::ST_FILL) |=>
        !$past(o_q_pop))
        else $error("command taken during scroll");

endmodule

// File: rtl/text_console_engine_core.sv
// Top level of the text console engine: front end, command queue and back end.
//
//  channel   direction  signals                                   handshake
//  command   in         i_cmd i_char_code i_color i_col_x         start & !busy
//                       i_row_y i_cell_index
//  result    out        o_cursor_pos o_cell_value o_scrolled      o_valid, one cycle
//  config    in         i_cfg_wdata (clear attribute)             i_cfg_we
//
//  Put char, newline, ignored codes and set cursor finish in the dispatch state of the
//  back end, unless a put at the last cell or a newline on the last row starts a scroll;
//  read cell adds the read state for the registered memory read. Clear writes one cell
//  per cycle after dispatch, and a scroll moves each row below the top one row up and
//  blanks the bottom row, all through the single write port of the cell memory.
//  After reset, busy stays high while the store is blanked.
//  busy rises when the two-entry queue is full; results are never held off.
module text_console_engine_core #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_char_code,
    input  logic [7:0]          i_color,
    input  logic signed [7:0]   i_col_x,
    input  logic signed [7:0]   i_row_y,
    input  logic [10:0]         i_cell_index,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    output logic                o_valid,
    output logic [10:0]         o_cursor_pos,
    output logic [15:0]         o_cell_value,
    output logic                o_scrolled
);

    tce_pkg::t_entry front_entry;
    tce_pkg::t_entry q_entry;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            init_busy;
    logic            accept;

    // Take a command beat when the queue has room and the store is ready
    assign busy   = q_full | init_busy;
    assign accept = start & ~busy;

    tce_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_cmd        (i_cmd),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_col_x      (i_col_x),
        .i_row_y      (i_row_y),
        .i_cell_index (i_cell_index),
        .o_entry      (front_entry)
    );

    tce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    tce_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_entry),
        .o_q_pop      (q_pop),
        .o_init_busy  (init_busy),
        .o_valid      (o_valid),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_value (o_cell_value),
        .o_scrolled   (o_scrolled)
    );

endmodule
